// File: design/assert_macros.svh
// Assertion macros shared by the RTL of the weighted average sensor filter.
// No dependencies; simulation builds get the checks, synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent check on an explicit clock and active-low reset.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check on the standard clk_i / rst_ni pair.
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLKD(label, clk_i, rst_ni, prop, msg)

`else

`define ASSERT_CLKD(label, clk, rst_n, prop, msg)
`define ASSERT_STD(label, prop, msg)

`endif

`endif

// File: design/wasf_pkg.sv
// Package for the weighted average sensor filter: field widths, config
// register indexes and the offset adder. No dependencies.
`timescale 1ns / 1ps

package wasf_pkg;

  localparam int WINDOW_LEN_DEF = 8;

  localparam int SAMPLE_W   = 16;
  localparam int OFFSET_W   = 16;
  localparam int LEVEL_W    = 18;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AVERAGE_ENABLE    = 1'b0,
    CFG_OFFSET_CORRECTION = 1'b1
  } cfg_reg_e;

  typedef logic [LEVEL_W-1:0] level_t;

  // Filtered level plus sign-extended offset, two's complement.
  function automatic level_t add_offset(input logic [SAMPLE_W-1:0] avg,
                                        input logic [OFFSET_W-1:0] offset);
    level_t avg_ext;
    level_t off_ext;
    avg_ext = {{(LEVEL_W-SAMPLE_W){1'b0}}, avg};
    off_ext = {{(LEVEL_W-OFFSET_W){offset[OFFSET_W-1]}}, offset};
    return avg_ext + off_ext;
  endfunction

endpackage

// File: design/wasf_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module wasf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/weighted_average_sensor_filter_unit.sv
// Top level of the weighted average sensor filter.
// Depends on wasf_pkg, wasf_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   Input channel: sample_i / sample_ok_i with in_valid_i, in_stall_o. A
//   transaction is taken on a clock edge with in_valid_i high, in_stall_o low.
//   Output channel: level_out_o / fault_o with out_valid_o, out_stall_i; one
//   result per input transaction, in order.
//   Config: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (0 = average
//   enable, 1 = signed offset); write only while the block is idle.
//   Sequence: a failed reading or a pass-through goes from accept straight to
//   S_DONE. With averaging on, the window walk visits each moved slot (RAM
//   read in S_READ, then multiply-accumulate and write-back in S_MAC) for slots
//   1 to WINDOW_LEN-2; S_FRESH and S_TOP handle the new sample, the restoring
//   divider runs in S_DIV, and S_ADJ and S_DONE finish.
//   One transaction is in work at a time; in_stall_o is high until it has
//   moved to the output register, so the next one is taken in the cycle after
//   that at the earliest. The output register holds one result so the next
//   reading can start while a stalled receiver keeps the previous one.
//   Reset: window empty (per-slot valid bits cleared), held level zero,
//   averaging off, offset zero, no result pending.
//   A stalled result stays on the output unchanged until taken.

module weighted_average_sensor_filter_unit #(
  parameter int WINDOW_LEN = wasf_pkg::WINDOW_LEN_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [wasf_pkg::SAMPLE_W-1:0]         sample_i,
  input  logic                                  sample_ok_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [wasf_pkg::LEVEL_W-1:0]   level_out_o,
  output logic                                  fault_o,
  input  logic                                  cfg_we_i,
  input  logic [wasf_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [wasf_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  import wasf_pkg::*;

  localparam int ADDR_W  = $clog2(WINDOW_LEN);
  localparam int WGT_MAX = WINDOW_LEN + (WINDOW_LEN * (WINDOW_LEN - 1)) / 2;
  localparam int WGT_W   = $clog2(WGT_MAX + 1);
  localparam int SUM_W   = SAMPLE_W + WGT_W;
  localparam int CNT_W   = $clog2(SAMPLE_W);

  localparam logic [ADDR_W-1:0] TOP_SLOT  = ADDR_W'(WINDOW_LEN - 1);
  localparam logic [ADDR_W-1:0] NEXT_SLOT = ADDR_W'(WINDOW_LEN - 2);
  localparam logic [ADDR_W:0]   FRESH_WT  = (ADDR_W + 1)'(2 * WINDOW_LEN - 1);
  localparam logic [WGT_W-1:0]  WGT_INIT  = WGT_W'(WINDOW_LEN);
  localparam logic [WGT_W-1:0]  WGT_NEXT  = WGT_W'(WINDOW_LEN - 1);
  localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(SAMPLE_W - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_FRESH = 3'd3;
  localparam logic [2:0] S_TOP   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_ADJ   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // control state
  logic [2:0]            state_q, state_d;
  logic [WINDOW_LEN-1:0] vld_q, vld_d;
  level_t                held_q, held_d;
  logic                  out_valid_q, out_valid_d;
  logic                  avg_en_q;
  logic [OFFSET_W-1:0]   offset_q;

  // payload / datapath
  logic [ADDR_W-1:0]   k_q, k_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [WGT_W-1:0]    wgt_q, wgt_d;
  logic [WGT_W-1:0]    rem_q, rem_d;
  logic [SAMPLE_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SAMPLE_W-1:0] fresh_q, fresh_d;
  logic                fault_q, fault_d;
  level_t              out_level_q, out_level_d;
  logic                out_fault_q, out_fault_d;

  // window RAM
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic                ram_re;
  logic [SAMPLE_W-1:0] ram_rdata;

  logic                         in_take;
  logic [SAMPLE_W-1:0]          rd_val;
  logic [SAMPLE_W+ADDR_W-1:0]   mac_prod;
  logic [SAMPLE_W+ADDR_W:0]     fresh_prod;
  logic [WGT_W:0]               div_trial;
  logic [WGT_W:0]               div_diff;
  logic                         div_ge;

  wasf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_LEN)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (k_q),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;

  // never-written slots read as empty
  assign rd_val     = vld_q[k_q] ? ram_rdata : '0;
  assign mac_prod   = (SAMPLE_W + ADDR_W)'(rd_val) * (SAMPLE_W + ADDR_W)'(k_q);
  assign fresh_prod = (SAMPLE_W + ADDR_W + 1)'(fresh_q) * (SAMPLE_W + ADDR_W + 1)'(FRESH_WT);

  assign div_trial = {rem_q, quo_q[SAMPLE_W-1]};
  assign div_ge    = (div_trial >= {1'b0, wgt_q});
  assign div_diff  = div_trial - {1'b0, wgt_q};

  always_comb begin
    state_d     = state_q;
    vld_d       = vld_q;
    held_d      = held_q;
    k_d         = k_q;
    sum_d       = sum_q;
    wgt_d       = wgt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    fresh_d     = fresh_q;
    fault_d     = fault_q;
    out_level_d = out_level_q;
    out_fault_d = out_fault_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;

    // output register drains independently of the sequencer
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          fresh_d = sample_i;
          fault_d = !sample_ok_i;
          k_d     = ADDR_W'(1);
          sum_d   = '0;
          wgt_d   = WGT_INIT;
          if (!sample_ok_i) begin
            state_d = S_DONE;
          end else if (!avg_en_q) begin
            held_d  = add_offset(sample_i, offset_q);
            state_d = S_DONE;
          end else if (TOP_SLOT == ADDR_W'(1)) begin
            state_d = S_FRESH;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        ram_re  = 1'b1;
        state_d = S_MAC;
      end
      S_MAC: begin
        // slot k-1 takes slot k only when slot k is occupied
        if (rd_val != '0) begin
          ram_we    = 1'b1;
          ram_waddr = k_q - ADDR_W'(1);
          ram_wdata = rd_val;
          sum_d     = sum_q + SUM_W'(mac_prod);
          wgt_d     = wgt_q + WGT_W'(k_q);
        end
        k_d = k_q + ADDR_W'(1);
        if (k_q + ADDR_W'(1) == TOP_SLOT) begin
          state_d = S_FRESH;
        end else begin
          state_d = S_READ;
        end
      end
      S_FRESH: begin
        // new sample counts with weight N, and again with N-1 if it shifts down
        sum_d = sum_q + SUM_W'(fresh_prod);
        if (fresh_q != '0) begin
          ram_we    = 1'b1;
          ram_waddr = NEXT_SLOT;
          ram_wdata = fresh_q;
          wgt_d     = wgt_q + WGT_NEXT;
        end
        state_d = S_TOP;
      end
      S_TOP: begin
        ram_we    = 1'b1;
        ram_waddr = TOP_SLOT;
        ram_wdata = fresh_q;
        // quotient fits 16 bits, so the upper part is already below the divisor
        rem_d     = sum_q[SUM_W-1:SAMPLE_W];
        quo_d     = sum_q[SAMPLE_W-1:0];
        cnt_d     = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        rem_d = div_ge ? div_diff[WGT_W-1:0] : div_trial[WGT_W-1:0];
        quo_d = {quo_q[SAMPLE_W-2:0], div_ge};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == DIV_LAST) begin
          state_d = S_ADJ;
        end
      end
      S_ADJ: begin
        held_d  = add_offset(quo_q, offset_q);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_level_d = held_q;
          out_fault_d = fault_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (ram_we) begin
      vld_d[ram_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vld_q       <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vld_q       <= vld_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_en_q <= 1'b0;
      offset_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_AVERAGE_ENABLE:    avg_en_q <= cfg_wdata_i[0];
        CFG_OFFSET_CORRECTION: offset_q <= cfg_wdata_i[OFFSET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    k_q         <= k_d;
    sum_q       <= sum_d;
    wgt_q       <= wgt_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    cnt_q       <= cnt_d;
    fresh_q     <= fresh_d;
    fault_q     <= fault_d;
    out_level_q <= out_level_d;
    out_fault_q <= out_fault_d;
  end

  assign out_valid_o = out_valid_q;
  assign level_out_o = out_level_q;
  assign fault_o     = out_fault_q;

  // window RAM never reads and writes the same slot in one cycle
  `ASSERT_STD(a_ram_no_overlap, !(ram_we && ram_re && (ram_waddr == k_q)), "RAM read/write collision")

  // divider remainder stays below the accumulated weight
  `ASSERT_STD(a_div_rem_bound, (state_q == S_DIV) |-> (rem_q < wgt_q), "divider remainder out of range")

  // weight count never drops below the window length while dividing
  `ASSERT_STD(a_div_wgt_min, (state_q == S_DIV) |-> (wgt_q >= WGT_INIT), "weight count too small")

  // a failed reading leaves the held level untouched
  `ASSERT_STD(a_fault_holds, (in_take && !sample_ok_i) |=> (held_q == $past(held_q)), "held level changed on fault")

endmodule

// File: dv/wasf_level_checker.sv
// Checker for the weighted average sensor filter: watches the config port and both
// channels, predicts each level and compares results in order. Depends on wasf_pkg.
`timescale 1ns / 1ps

module wasf_level_checker #(
  parameter int WINDOW_LEN = wasf_pkg::WINDOW_LEN_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic [wasf_pkg::SAMPLE_W-1:0]       sample_i,
  input  logic                                sample_ok_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic [wasf_pkg::LEVEL_W-1:0]        level_i,
  input  logic                                fault_i,
  input  logic                                cfg_we_i,
  input  logic [wasf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wasf_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output int                                  mismatch_cnt_o,
  output int                                  pending_o,
  output int                                  checked_o
);

  import wasf_pkg::*;

  localparam int REPORT_MAX = 100;

  typedef struct packed {
    level_t level;
    logic   fault;
  } level_result_t;

  level_result_t expected_levels_q[$];

  logic [SAMPLE_W-1:0]        window_q [WINDOW_LEN];
  level_t                     held_q;
  logic                       avg_en_q;
  logic signed [OFFSET_W-1:0] offset_q;
  int                         mismatches;
  int                         checked;

  task automatic report_mismatch(input string what);
    if (mismatches < REPORT_MAX) begin
      $display("%0t ns: level mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  // Shift the window down over nonzero slots and take the weighted mean.
  function automatic logic [SAMPLE_W-1:0] window_average(input logic [SAMPLE_W-1:0] fresh);
    longint unsigned acc;
    longint unsigned weight;
    acc    = 0;
    weight = WINDOW_LEN;
    window_q[WINDOW_LEN-1] = fresh;
    for (int i = 0; i < WINDOW_LEN - 1; i++) begin
      if (window_q[i+1] != '0) begin
        window_q[i] = window_q[i+1];
        acc += longint'(window_q[i]) * longint'(i + 1);
        weight += i + 1;
      end
    end
    acc += longint'(fresh) * longint'(WINDOW_LEN);
    return SAMPLE_W'(acc / weight);
  endfunction

  function automatic level_result_t filter_reading(input logic [SAMPLE_W-1:0] sample,
                                                   input logic ok);
    level_result_t r;
    logic [SAMPLE_W-1:0] avg;
    int lvl;
    if (ok) begin
      avg = avg_en_q ? window_average(sample) : sample;
      lvl = int'(avg) + int'(offset_q);
      held_q = level_t'(lvl);
      r.fault = 1'b0;
    end else begin
      r.fault = 1'b1;
    end
    r.level = held_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    level_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) window_q[i] = '0;
      held_q   = '0;
      avg_en_q = 1'b0;
      offset_q = '0;
      mismatches = 0;
      checked    = 0;
      expected_levels_q.delete();
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
      checked_o      <= 0;
    end else begin
      // a result can never belong to the transaction taken on this same edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_levels_q.size() == 0) begin
          report_mismatch($sformatf("result level %0d fault %0b with nothing pending",
                                    $signed(level_i), fault_i));
        end else begin
          want = expected_levels_q.pop_front();
          if (level_i !== want.level) begin
            report_mismatch($sformatf("level_out got %0d want %0d",
                                      $signed(level_i), $signed(want.level)));
          end
          if (fault_i !== want.fault) begin
            report_mismatch($sformatf("fault got %0b want %0b", fault_i, want.fault));
          end
          checked++;
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_AVERAGE_ENABLE) begin
          avg_en_q = cfg_wdata_i[0];
        end else if (cfg_idx_i == CFG_OFFSET_CORRECTION) begin
          offset_q = cfg_wdata_i[OFFSET_W-1:0];
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_levels_q.push_back(filter_reading(sample_i, sample_ok_i));
      end
      mismatch_cnt_o <= mismatches;
      pending_o      <= expected_levels_q.size();
      checked_o      <= checked;
    end
  end

endmodule

// File: dv/weighted_average_sensor_filter_unit_tb.sv
// Top of the filter testbench: clock, reset, config writes, reading stimulus and
// output stalls. Depends on wasf_pkg, the filter RTL and wasf_level_checker.
`timescale 1ns / 1ps

module weighted_average_sensor_filter_unit_tb;

  import wasf_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int SEG_ITEMS    = 280;
  localparam int SEGMENTS     = 6;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [SAMPLE_W-1:0]   sample_i    = '0;
  logic                  sample_ok_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [LEVEL_W-1:0] level_out_o;
  logic                  fault_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = CFG_AVERAGE_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  int mismatch_cnt;
  int pending_cnt;
  int checked_cnt;

  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic hold_req    = 1'b0;
  logic hold_done   = 1'b0;
  int   hold_cnt    = 0;

  int readings_sent = 0;
  int faults_sent   = 0;
  int settings_used = 0;

  weighted_average_sensor_filter_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .sample_ok_i (sample_ok_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .level_out_o (level_out_o),
    .fault_o     (fault_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  wasf_level_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .sample_i       (sample_i),
    .sample_ok_i    (sample_ok_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .level_i        (level_out_o),
    .fault_i        (fault_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt),
    .checked_o      (checked_cnt)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Output side: random stalls, plus one long hold-off so the block backs up.
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_cnt++;
      if (hold_cnt == HOLD_CYCLES) hold_done = 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding", LIMIT_CYCLES, pending_cnt);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_reading(input logic [SAMPLE_W-1:0] sample, input logic ok);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_i    <= sample;
    sample_ok_i <= ok;
    do @(posedge clk_i); while (in_stall_o);
    readings_sent++;
    if (!ok) faults_sent++;
  endtask

  task automatic drain_levels();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Registers only change once the block has gone quiet.
  task automatic set_filter(input logic avg_en, input logic [OFFSET_W-1:0] offset);
    drain_levels();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_AVERAGE_ENABLE;
    cfg_wdata_i <= {{(CFG_DATA_W-1){1'b0}}, avg_en};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_OFFSET_CORRECTION;
    cfg_wdata_i <= offset;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_used++;
  endtask

  // Mostly plain readings, with zeros (empty slots), extremes and failures mixed in.
  task automatic send_random_reading();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10)      send_reading(SAMPLE_W'($urandom), 1'b0);
    else if (pick < 20) send_reading('0, 1'b1);
    else if (pick < 28) send_reading('1, 1'b1);
    else if (pick < 34) send_reading(SAMPLE_W'($urandom_range(1, 15)), 1'b1);
    else                send_reading(SAMPLE_W'($urandom), 1'b1);
  endtask

  initial begin
    logic [OFFSET_W-1:0] seg_offset;
    logic                seg_avg;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 6;
    rx_idle_pct <= 85;

    // pass-through at the level extremes, failure holds the last level
    set_filter(1'b0, 16'h0000);
    send_reading(16'h0000, 1'b1);
    send_reading(16'hFFFF, 1'b1);
    send_reading(16'hA5A5, 1'b0);
    set_filter(1'b0, 16'h8000);
    send_reading(16'h0000, 1'b1);
    send_reading(16'hFFFF, 1'b1);
    set_filter(1'b0, 16'h7FFF);
    send_reading(16'hFFFF, 1'b1);
    send_reading(16'h5A5A, 1'b0);
    // averaging from an empty window; zero readings leave gaps behind
    set_filter(1'b1, 16'h0000);
    send_reading(16'd100, 1'b1);
    send_reading(16'h0000, 1'b1);
    send_reading(16'h0000, 1'b1);
    send_reading(16'd200, 1'b1);
    send_reading(16'hFFFF, 1'b1);
    send_reading(16'hFFFF, 1'b1);
    send_reading(16'hFFFF, 1'b1);
    send_reading(16'h0001, 1'b1);
    send_reading(16'd1234, 1'b0);
    send_reading(16'h0000, 1'b1);
    set_filter(1'b1, 16'h8000);
    send_reading(16'h0000, 1'b1);
    send_reading(16'hFFFF, 1'b1);
    set_filter(1'b1, 16'h7FFF);
    send_reading(16'hFFFF, 1'b1);
    send_reading(16'hFFFF, 1'b1);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin seg_avg = 1'b1; seg_offset = 16'h0000; end
        1: begin seg_avg = 1'b1; seg_offset = OFFSET_W'($urandom); end
        2: begin seg_avg = 1'b0; seg_offset = OFFSET_W'($urandom); end
        3: begin seg_avg = 1'b1; seg_offset = 16'h7FFF; end
        4: begin seg_avg = 1'b1; seg_offset = 16'h8000; end
        default: begin seg_avg = 1'b1; seg_offset = OFFSET_W'($urandom); end
      endcase
      set_filter(seg_avg, seg_offset);
      case (seg / 2)
        0: begin tx_idle_pct = 6;  rx_idle_pct <= 85; end
        1: begin tx_idle_pct = 85; rx_idle_pct <= 6;  end
        default: begin tx_idle_pct = 0; rx_idle_pct <= 0; end
      endcase
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if (seg == 4 && n == 50) hold_req <= 1'b1;
        send_random_reading();
      end
    end

    drain_levels();
    $display("covered %0d readings (%0d sensor failures), %0d results checked",
             readings_sent, faults_sent, checked_cnt);
    $display("across %0d filter settings, three idle profiles and a %0d-cycle output hold",
             settings_used, HOLD_CYCLES);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_cnt, pending_cnt);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/wasf_pkg.sv
design/wasf_ram.sv
design/weighted_average_sensor_filter_unit.sv
dv/wasf_level_checker.sv
dv/weighted_average_sensor_filter_unit_tb.sv
